### design/fpba_pkg.sv
package fpba_pkg;

   // table geometry
   localparam int MAX_BLOCKS = 16;
   localparam int SIZE_BITS  = 16;
   localparam int IDX_BITS   = $clog2(MAX_BLOCKS);
   localparam int CNT_BITS   = $clog2(MAX_BLOCKS + 1);

   // placement policies
   localparam logic [1:0] POLICY_FIRST = 2'd0;
   localparam logic [1:0] POLICY_BEST  = 2'd1;
   localparam logic [1:0] POLICY_WORST = 2'd2;
   localparam logic [1:0] POLICY_NEXT  = 2'd3;

   // item actions
   localparam logic ACTION_LOAD  = 1'b0;
   localparam logic ACTION_ALLOC = 1'b1;

   // register indexes
   localparam logic CSR_POLICY      = 1'b0;
   localparam logic CSR_BLOCK_COUNT = 1'b1;

   localparam int CSR_DATA_BITS = 5;

   typedef struct packed {
      logic                 action;
      logic [IDX_BITS-1:0]  block_index;
      logic [SIZE_BITS-1:0] amount;
   } req_item_type;

   typedef struct packed {
      logic                 granted;
      logic [IDX_BITS-1:0]  chosen_block;
      logic [SIZE_BITS-1:0] space_left;
   } rsp_item_type;

endpackage

### design/fit_policy_block_allocator_unit.sv
// channel   direction  handshake              payload
// req       in         req_valid/req_ready    req_item  (action, block_index, amount)
// rsp       out        rsp_valid/rsp_ready    rsp_item  (granted, chosen_block, space_left)
// csr       in         csr_write_enable       csr_index, csr_wdata
//
// One item at a time. A load goes straight to the final state, which registers
// its result. An allocate reads the searched blocks (block_count clipped to the
// table size); the free-space memory has one read port, so the scan reads one
// entry per cycle; first and next fit stop at the first hit. The block returns
// to idle as the result is registered, ready for the next item. Reset is
// synchronous; the table reads as zero after reset through per-entry valid bits,
// no clearing pass. A stalled rsp holds the result in the output register; the
// block waits in its final state until the output register is free.
module fit_policy_block_allocator_unit
   import fpba_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  req_item_type             req_item,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output rsp_item_type             rsp_item,
   input  logic                     csr_write_enable,
   input  logic                     csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata
);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SCAN   = 3'b010,
      ST_FINISH = 3'b100
   } state_type;

   // free-space table: registered synchronous read
   logic [SIZE_BITS-1:0] mem [MAX_BLOCKS];
   logic [SIZE_BITS-1:0] mem_rd_ff;
   logic                 mem_we;
   logic [IDX_BITS-1:0]  mem_waddr;
   logic [SIZE_BITS-1:0] mem_wdata;

   // per-entry written marks: unwritten entries read as zero
   logic [MAX_BLOCKS-1:0] valid_ff, valid_in;
   logic                  vld_rd_ff;

   state_type state_ff, state_in;

   logic [1:0]          policy_ff, policy_in;
   logic [4:0]          block_count_ff, block_count_in;
   logic [IDX_BITS-1:0] ptr_ff, ptr_in;

   // latched item
   logic                 act_ff, act_in;
   logic [SIZE_BITS-1:0] amt_ff, amt_in;
   logic [CNT_BITS-1:0]  cnt_ff, cnt_in;

   // scan control
   logic [IDX_BITS-1:0] pos_ff, pos_in;
   logic [CNT_BITS-1:0] issued_ff, issued_in;
   logic                rd_valid_ff, rd_valid_in;
   logic [IDX_BITS-1:0] rd_idx_ff, rd_idx_in;

   // search result
   logic                 found_ff, found_in;
   logic [IDX_BITS-1:0]  pick_ff, pick_in;
   logic [SIZE_BITS-1:0] best_ff, best_in;

   logic         rsp_valid_ff, rsp_valid_in;
   rsp_item_type rsp_item_ff, rsp_item_in;

   logic [CNT_BITS-1:0]  search_cnt;
   logic [CNT_BITS-1:0]  pos_next;
   logic [SIZE_BITS-1:0] cur_s;
   logic                 fit;
   logic                 issue;
   logic                 out_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   // blocks searched: block_count clipped to the table size
   assign search_cnt = (block_count_ff > 5'(MAX_BLOCKS)) ? CNT_BITS'(MAX_BLOCKS)
                                                        : CNT_BITS'(block_count_ff);

   assign cur_s    = vld_rd_ff ? mem_rd_ff : '0;
   assign fit      = (cur_s >= amt_ff);
   assign issue    = (state_ff == ST_SCAN) && (issued_ff < cnt_ff);
   assign pos_next = CNT_BITS'(pos_ff) + CNT_BITS'(1);
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in       = state_ff;
      policy_in      = policy_ff;
      block_count_in = block_count_ff;
      ptr_in         = ptr_ff;
      act_in         = act_ff;
      amt_in         = amt_ff;
      cnt_in         = cnt_ff;
      pos_in         = pos_ff;
      issued_in      = issued_ff;
      rd_valid_in    = 1'b0;
      rd_idx_in      = pos_ff;
      found_in       = found_ff;
      pick_in        = pick_ff;
      best_in        = best_ff;
      valid_in       = valid_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_item_in    = rsp_item_ff;
      mem_we         = 1'b0;
      mem_waddr      = pick_ff;
      mem_wdata      = (act_ff == ACTION_LOAD) ? amt_ff : best_ff - amt_ff;

      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_POLICY:      policy_in      = csr_wdata[1:0];
            CSR_BLOCK_COUNT: block_count_in = csr_wdata[4:0];
            default:         ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               act_in    = req_item.action;
               amt_in    = req_item.amount;
               cnt_in    = search_cnt;
               issued_in = '0;
               best_in   = '0;
               if (req_item.action == ACTION_LOAD) begin
                  found_in = 1'b1;
                  pick_in  = req_item.block_index;
                  state_in = ST_FINISH;
               end else begin
                  found_in = 1'b0;
                  pick_in  = '0;
                  // next fit starts at the pointer if it lies in range
                  if (policy_ff == POLICY_NEXT && CNT_BITS'(ptr_ff) < search_cnt) begin
                     pos_in = ptr_ff;
                  end else begin
                     pos_in = '0;
                  end
                  state_in = ST_SCAN;
               end
            end
         end

         ST_SCAN: begin
            if (issue) begin
               rd_valid_in = 1'b1;
               issued_in   = issued_ff + CNT_BITS'(1);
               pos_in      = (pos_next == cnt_ff) ? '0 : pos_next[IDX_BITS-1:0];
            end
            if (rd_valid_ff && fit) begin
               priority case (policy_ff)
                  POLICY_FIRST, POLICY_NEXT: begin
                     // first hit in scan order ends the search
                     found_in    = 1'b1;
                     pick_in     = rd_idx_ff;
                     best_in     = cur_s;
                     rd_valid_in = 1'b0;
                     state_in    = ST_FINISH;
                  end
                  POLICY_BEST: begin
                     if (!found_ff || cur_s < best_ff) begin
                        found_in = 1'b1;
                        pick_in  = rd_idx_ff;
                        best_in  = cur_s;
                     end
                  end
                  default: begin
                     if (!found_ff || cur_s > best_ff) begin
                        found_in = 1'b1;
                        pick_in  = rd_idx_ff;
                        best_in  = cur_s;
                     end
                  end
               endcase
            end
            // all reads issued and the last one evaluated
            if (!issue && !rd_valid_ff) begin
               state_in = ST_FINISH;
            end
         end

         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (found_ff) begin
                  mem_we                   = 1'b1;
                  valid_in[pick_ff]        = 1'b1;
                  rsp_item_in.granted      = 1'b1;
                  rsp_item_in.chosen_block = pick_ff;
                  rsp_item_in.space_left   = mem_wdata;
                  if (act_ff == ACTION_ALLOC && policy_ff == POLICY_NEXT) begin
                     ptr_in = pick_ff;
                  end
               end else begin
                  rsp_item_in.granted      = 1'b0;
                  rsp_item_in.chosen_block = '0;
                  rsp_item_in.space_left   = '0;
               end
               state_in = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         policy_ff      <= POLICY_FIRST;
         block_count_ff <= 5'(MAX_BLOCKS);
         ptr_ff         <= '0;
         valid_ff       <= '0;
         rd_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         issued_ff      <= '0;
         found_ff       <= 1'b0;
      end else begin
         state_ff       <= state_in;
         policy_ff      <= policy_in;
         block_count_ff <= block_count_in;
         ptr_ff         <= ptr_in;
         valid_ff       <= valid_in;
         rd_valid_ff    <= rd_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         issued_ff      <= issued_in;
         found_ff       <= found_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      act_ff      <= act_in;
      amt_ff      <= amt_in;
      cnt_ff      <= cnt_in;
      pos_ff      <= pos_in;
      rd_idx_ff   <= rd_idx_in;
      pick_ff     <= pick_in;
      best_ff     <= best_in;
      rsp_item_ff <= rsp_item_in;
   end

   // table memory
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      mem_rd_ff <= mem[pos_ff];
      vld_rd_ff <= valid_ff[pos_ff];
   end

endmodule
